// ===== sv/aalg_pkg.sv =====
// ----------------------------------------------------------------------------
// aalg_pkg
// Shared widths, constants and command codes of the antialiased line generator
// ----------------------------------------------------------------------------
package aalg_pkg;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 16;
    localparam int ALPHA_BITS  = 8;

    localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 8'hFF;

    // coverage times this scale must reach 1.0 for a visible pixel
    localparam int VIS_SCALE = 100;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

endpackage

// ===== sv/antialiased_line_generator_core.sv =====
// ----------------------------------------------------------------------------
// antialiased_line_generator_core
// Wu antialiased line rasterizer with fixed-point slope and coverage alpha
// ----------------------------------------------------------------------------
// A start command (command 0) takes two endpoints and yields the four
// endpoint-cap pixels; each advance command (command 1) yields the two
// pixels of the next interior column, the final one flagged by last.
// Input and pixel channels use valid/stall: a transfer happens on a clock
// edge with valid high and stall low. in_stall is high while an item is
// being worked on, so one item is handled at a time.
// A start is decoded, then runs through the restoring divider (one quotient
// bit per cycle, skipped for a zero-length line), then emits the four caps.
// An advance is decoded and then emits its two pixels one after the other.
// An advance with no line active produces no pixel.
// A single output register holds a pixel while the receiver stalls; the
// sequencer waits for it to drain, so nothing is lost or repeated.
// Reset clears the line state and sets color_alpha to 255. The user is to
// write the color_alpha register over the cfg channel only while idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module antialiased_line_generator_core #(
    parameter int FRAC_BITS = aalg_pkg::FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [aalg_pkg::COORD_BITS-1:0]     x_start,
    input  logic [aalg_pkg::COORD_BITS-1:0]     y_start,
    input  logic [aalg_pkg::COORD_BITS-1:0]     x_end,
    input  logic [aalg_pkg::COORD_BITS-1:0]     y_end,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [aalg_pkg::COORD_BITS:0]       pixel_x,
    output logic [aalg_pkg::COORD_BITS:0]       pixel_y,
    output logic [aalg_pkg::ALPHA_BITS-1:0]     pixel_alpha,
    output logic                                visible,
    output logic                                last,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aalg_pkg::ALPHA_BITS-1:0]     cfg_data
);

    localparam int CB = aalg_pkg::COORD_BITS;
    localparam int AB = aalg_pkg::ALPHA_BITS;
    localparam int QW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 2;
    localparam int IW = CB + FRAC_BITS + 2;
    localparam int RW = CB + 2;
    localparam int NW = CB + FRAC_BITS + 1;
    localparam int PW = QW + AB;
    localparam int VW = FRAC_BITS + 8;

    localparam logic [QW-1:0] COV_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [QW-1:0] COV_HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};
    localparam logic [1:0]    PIX_LAST = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_CAP  = 4'b0100,
        ST_COL  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      pix_reg, pix_next;
    logic            line_active_reg, line_active_next;
    logic            steep_reg, steep_next;
    logic            zero_reg, zero_next;
    logic            dyneg_reg, dyneg_next;
    logic [CB-1:0]   x0_reg, x0_next;
    logic [CB-1:0]   y0_reg, y0_next;
    logic [CB-1:0]   x1_reg, x1_next;
    logic [CB-1:0]   y1_reg, y1_next;
    logic [CB:0]     column_now_reg, column_now_next;
    logic [CB:0]     column_stop_reg, column_stop_next;
    logic [IW-1:0]   intercept_reg, intercept_next;
    logic [SW-1:0]   slope_reg, slope_next;
    logic [AB-1:0]   color_alpha_reg;
    logic            out_valid_reg;

    logic [CB:0]     pixel_x_reg;
    logic [CB:0]     pixel_y_reg;
    logic [AB-1:0]   pixel_alpha_reg;
    logic            visible_reg;
    logic            last_reg;

    logic            in_accept;
    logic            emit;
    logic            div_start;
    logic            div_done;
    logic [QW-1:0]   div_quot;

    logic [CB-1:0]   adx, ady, a0, b0, a1, b1;
    logic [CB-1:0]   ox0, oy0, ox1, oy1, dxw, mag;
    logic            steep, swp, dyneg;
    logic [NW-1:0]   numer;

    logic [SW-1:0]   slope_calc;
    logic [CB:0]     col_first;
    logic            fin;

    logic [CB:0]     sel_col;
    logic [RW-1:0]   sel_row;
    logic [QW-1:0]   sel_cov;
    logic            sel_last;
    logic [RW-1:0]   base;
    logic [PW-1:0]   alpha_prod;
    logic [VW-1:0]   cov_scaled;
    logic            row_neg;
    logic [CB:0]     row_pix;
    logic [AB-1:0]   pix_alpha;
    logic            pix_vis;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign emit      = ((state_reg == ST_CAP) || (state_reg == ST_COL))
                       && (!out_valid_reg || !out_stall);

    // endpoint decode: steep swap, then order by major coordinate
    always_comb
    begin
        adx   = (x_end >= x_start) ? x_end - x_start : x_start - x_end;
        ady   = (y_end >= y_start) ? y_end - y_start : y_start - y_end;
        steep = ady > adx;
        a0    = steep ? y_start : x_start;
        b0    = steep ? x_start : y_start;
        a1    = steep ? y_end : x_end;
        b1    = steep ? x_end : y_end;
        swp   = a0 > a1;
        ox0   = swp ? a1 : a0;
        oy0   = swp ? b1 : b0;
        ox1   = swp ? a0 : a1;
        oy1   = swp ? b0 : b1;
        dxw   = ox1 - ox0;
        dyneg = oy0 > oy1;
        mag   = dyneg ? oy0 - oy1 : oy1 - oy0;
        numer = {1'b0, mag, {FRAC_BITS{1'b0}}} + NW'(dxw >> 1);
    end

    aalg_divider #(
        .COORD_BITS (CB),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (numer),
        .denom (dxw),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        if (zero_reg)
            slope_calc = SW'(COV_ONE);
        else if (dyneg_reg)
            slope_calc = SW'(0) - {1'b0, div_quot};
        else
            slope_calc = {1'b0, div_quot};
    end

    assign col_first = {1'b0, x0_reg} + (CB+1)'(1);
    assign fin       = (column_now_reg + (CB+1)'(1)) >= column_stop_reg;
    assign base      = intercept_reg[IW-1:FRAC_BITS];

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        pix_next         = pix_reg;
        line_active_next = line_active_reg;
        steep_next       = steep_reg;
        zero_next        = zero_reg;
        dyneg_next       = dyneg_reg;
        x0_next          = x0_reg;
        y0_next          = y0_reg;
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        column_now_next  = column_now_reg;
        column_stop_next = column_stop_reg;
        intercept_next   = intercept_reg;
        slope_next       = slope_reg;
        div_start        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (command == aalg_pkg::CMD_START)
                    begin
                        steep_next = steep;
                        dyneg_next = dyneg;
                        zero_next  = (dxw == '0);
                        div_start  = (dxw != '0);
                        x0_next    = ox0;
                        y0_next    = oy0;
                        x1_next    = ox1;
                        y1_next    = oy1;
                        state_next = ST_DIV;
                    end
                    else if (line_active_reg)
                    begin
                        pix_next   = '0;
                        state_next = ST_COL;
                    end
                end
            end
            ST_DIV:
            begin
                if (zero_reg || div_done)
                begin
                    slope_next       = slope_calc;
                    intercept_next   = {2'b00, y0_reg, {FRAC_BITS{1'b0}}}
                                       + {{(IW-SW){slope_calc[SW-1]}}, slope_calc};
                    column_now_next  = col_first;
                    column_stop_next = {1'b0, x1_reg};
                    line_active_next = col_first < {1'b0, x1_reg};
                    pix_next         = '0;
                    state_next       = ST_CAP;
                end
            end
            ST_CAP:
            begin
                if (emit)
                begin
                    pix_next = pix_reg + 2'd1;
                    if (pix_reg == PIX_LAST)
                        state_next = ST_IDLE;
                end
            end
            ST_COL:
            begin
                if (emit)
                begin
                    if (pix_reg == '0)
                        pix_next = 2'd1;
                    else
                    begin
                        intercept_next  = intercept_reg
                                          + {{(IW-SW){slope_reg[SW-1]}}, slope_reg};
                        column_now_next = column_now_reg + (CB+1)'(1);
                        if (fin)
                            line_active_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // pixel selection
    always_comb
    begin
        sel_col  = column_now_reg;
        sel_row  = base;
        sel_cov  = COV_ONE - {1'b0, intercept_reg[FRAC_BITS-1:0]};
        sel_last = 1'b0;
        if (state_reg == ST_COL)
        begin
            if (pix_reg != '0)
            begin
                sel_row  = base + RW'(1);
                sel_cov  = {1'b0, intercept_reg[FRAC_BITS-1:0]};
                sel_last = fin;
            end
        end
        else
        begin
            case (pix_reg)
                2'd0:
                begin
                    sel_col = {1'b0, x0_reg};
                    sel_row = {2'b00, y0_reg};
                    sel_cov = COV_HALF;
                end
                2'd1:
                begin
                    sel_col = {1'b0, x0_reg};
                    sel_row = {2'b00, y0_reg} + RW'(1);
                    sel_cov = '0;
                end
                2'd2:
                begin
                    sel_col = {1'b0, x1_reg};
                    sel_row = {2'b00, y1_reg};
                    sel_cov = COV_HALF;
                end
                default:
                begin
                    sel_col  = {1'b0, x1_reg};
                    sel_row  = {2'b00, y1_reg} + RW'(1);
                    sel_cov  = '0;
                    sel_last = !line_active_reg;
                end
            endcase
        end
    end

    // coverage to alpha and visibility
    assign alpha_prod = PW'(sel_cov) * PW'(color_alpha_reg);
    assign cov_scaled = VW'(sel_cov) * VW'(aalg_pkg::VIS_SCALE);
    assign row_neg    = sel_row[RW-1];
    assign row_pix    = row_neg ? '0 : sel_row[CB:0];
    assign pix_alpha  = row_neg ? '0 : alpha_prod[FRAC_BITS +: AB];
    assign pix_vis    = !row_neg && (cov_scaled >= VW'(COV_ONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            pix_reg         <= '0;
            line_active_reg <= 1'b0;
            steep_reg       <= 1'b0;
            zero_reg        <= 1'b0;
            dyneg_reg       <= 1'b0;
            column_now_reg  <= '0;
            column_stop_reg <= '0;
            intercept_reg   <= '0;
            slope_reg       <= '0;
            color_alpha_reg <= aalg_pkg::ALPHA_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pix_reg         <= pix_next;
            line_active_reg <= line_active_next;
            steep_reg       <= steep_next;
            zero_reg        <= zero_next;
            dyneg_reg       <= dyneg_next;
            column_now_reg  <= column_now_next;
            column_stop_reg <= column_stop_next;
            intercept_reg   <= intercept_next;
            slope_reg       <= slope_next;
            if (cfg_valid && cfg_ready)
                color_alpha_reg <= cfg_data;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg <= x0_next;
        y0_reg <= y0_next;
        x1_reg <= x1_next;
        y1_reg <= y1_next;
        if (emit)
        begin
            pixel_x_reg     <= steep_reg ? row_pix : sel_col;
            pixel_y_reg     <= steep_reg ? sel_col : row_pix;
            pixel_alpha_reg <= pix_alpha;
            visible_reg     <= pix_vis;
            last_reg        <= sel_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_alpha = pixel_alpha_reg;
    assign visible     = visible_reg;
    assign last        = last_reg;

endmodule

// ===== sv/aalg_divider.sv =====
// ----------------------------------------------------------------------------
// aalg_divider
// Iterative restoring divider for the line slope, one quotient bit per cycle
// ----------------------------------------------------------------------------
module aalg_divider #(
    parameter int COORD_BITS = aalg_pkg::COORD_BITS,
    parameter int FRAC_BITS  = aalg_pkg::FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [COORD_BITS+FRAC_BITS:0]   numer,
    input  logic [COORD_BITS-1:0]           denom,
    output logic                            done,
    output logic [FRAC_BITS:0]              quot
);

    localparam int QW    = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(QW + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [QW-1:0]         low_reg, low_next;
    logic [QW-1:0]         quot_reg, quot_next;
    logic [COORD_BITS-1:0] dvs_reg, dvs_next;

    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  qbit;

    // the top bits of the numerator are already below the divisor
    assign trial = {rem_reg, low_reg[QW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QW);
            rem_next  = numer[COORD_BITS+FRAC_BITS:QW];
            low_next  = numer[QW-1:0];
            quot_next = '0;
            dvs_next  = denom;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            low_next  = {low_reg[QW-2:0], 1'b0};
            quot_next = {quot_reg[QW-2:0], qbit};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for antialiased_line_generator_core
// ----------------------------------------------------------------------------
// Line commands are queued per phase and sent by a clocked driver. Each
// accepted command is run through a local Wu line predictor, which queues
// the pixels it expects. A clocked monitor checks every pixel transfer
// against the oldest expected pixel. The bench covers directed endpoint
// extremes, random well-formed lines with some abandoned or padded with
// idle advances, a long receiver hold-off, and several color_alpha
// settings written while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int     CB             = aalg_pkg::COORD_BITS;
    localparam int     FB             = aalg_pkg::FRAC_BITS;
    localparam int     AB             = aalg_pkg::ALPHA_BITS;
    localparam longint ONE_Q          = longint'(1) << FB;
    localparam longint FRAC_MASK_Q    = ONE_Q - 1;
    localparam int     COORD_MAX      = (1 << CB) - 1;
    localparam int     SETTLE_CYCLES  = FB + 24;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     HOLD_CYCLES    = 150;

    typedef struct packed {
        logic          command;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
    } line_cmd_t;

    typedef struct packed {
        logic [CB:0]   x;
        logic [CB:0]   y;
        logic [AB-1:0] alpha;
        logic          vis;
        logic          fin;
    } pixel_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic          command = aalg_pkg::CMD_START;
    logic [CB-1:0] x_start = '0;
    logic [CB-1:0] y_start = '0;
    logic [CB-1:0] x_end = '0;
    logic [CB-1:0] y_end = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [CB:0]   pixel_x;
    logic [CB:0]   pixel_y;
    logic [AB-1:0] pixel_alpha;
    logic          visible;
    logic          last;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [AB-1:0] cfg_data;

    line_cmd_t pending_cmds[$];
    pixel_t    expected_pixels[$];

    // line predictor state
    logic [AB-1:0] alpha_now = aalg_pkg::ALPHA_RESET;
    bit            line_on   = 1'b0;
    bit            steep_on  = 1'b0;
    logic [CB:0]   col_next  = '0;
    logic [CB:0]   col_last  = '0;
    longint        icpt      = 0;
    longint        grad      = 0;

    bit sender_gaps     = 1'b1;
    bit receiver_stalls = 1'b1;
    bit hold_request    = 1'b0;

    int errors         = 0;
    int cmds_in        = 0;
    int pixels_checked = 0;
    int alpha_writes   = 0;
    int holds_done     = 0;
    int steep_lines    = 0;
    int hidden_pixels  = 0;
    int clipped_pixels = 0;
    int items_planned  = 0;

    antialiased_line_generator_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_alpha (pixel_alpha),
        .visible     (visible),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int gap_length();
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    task automatic push_pixel(input longint col, input longint row, input longint cov,
                              input bit fin);
        pixel_t p;
        longint cv;
        longint c;
        longint r;
        begin
            cv = (cov < 0) ? 0 : ((cov > ONE_Q) ? ONE_Q : cov);
            c = (col < 0) ? 0 : col;
            r = (row < 0) ? 0 : row;
            p.alpha = AB'((cv * longint'(alpha_now)) >> FB);
            p.vis = (cv * aalg_pkg::VIS_SCALE) >= ONE_Q;
            if (col < 0 || row < 0)
            begin
                p.alpha = '0;
                p.vis = 1'b0;
                clipped_pixels++;
            end
            p.x = (CB+1)'(steep_on ? r : c);
            p.y = (CB+1)'(steep_on ? c : r);
            p.fin = fin;
            if (!p.vis)
                hidden_pixels++;
            expected_pixels.insert(expected_pixels.size(), p);
        end
    endtask

    task automatic predict_line_cmd(input line_cmd_t c);
        longint x0;
        longint y0;
        longint x1;
        longint y1;
        longint t;
        longint dx;
        longint dy;
        longint adx;
        longint ady;
        longint mag;
        longint fr;
        longint base;
        bit no_cols;
        bit fin;
        begin
            if (c.command == aalg_pkg::CMD_START)
            begin
                x0 = longint'(c.xs);
                y0 = longint'(c.ys);
                x1 = longint'(c.xe);
                y1 = longint'(c.ye);
                adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
                ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
                steep_on = ady > adx;
                if (steep_on)
                begin
                    steep_lines++;
                    t = x0; x0 = y0; y0 = t;
                    t = x1; x1 = y1; y1 = t;
                end
                if (x0 > x1)
                begin
                    t = x0; x0 = x1; x1 = t;
                    t = y0; y0 = y1; y1 = t;
                end
                dx = x1 - x0;
                dy = y1 - y0;
                if (dx == 0)
                    grad = ONE_Q;
                else
                begin
                    mag = (dy < 0) ? -dy : dy;
                    grad = ((mag << FB) + dx / 2) / dx;
                    if (dy < 0)
                        grad = -grad;
                end
                icpt = y0 * ONE_Q + grad;
                col_next = (CB+1)'(x0 + 1);
                col_last = (CB+1)'(x1);
                no_cols = (x0 + 1) >= x1;
                line_on = !no_cols;
                push_pixel(x0, y0, ONE_Q / 2, 1'b0);
                push_pixel(x0, y0 + 1, 0, 1'b0);
                push_pixel(x1, y1, ONE_Q / 2, 1'b0);
                push_pixel(x1, y1 + 1, 0, no_cols);
            end
            else if (line_on)
            begin
                fr = icpt & FRAC_MASK_Q;
                base = (icpt - fr) >>> FB;
                fin = (longint'(col_next) + 1) >= longint'(col_last);
                push_pixel(longint'(col_next), base, ONE_Q - fr, 1'b0);
                push_pixel(longint'(col_next), base + 1, fr, fin);
                icpt = icpt + grad;
                col_next = col_next + (CB+1)'(1);
                if (fin)
                    line_on = 1'b0;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // sender
    line_cmd_t cur_cmd;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_line_cmd(cur_cmd);
                cmds_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    command <= cur_cmd.command;
                    x_start <= cur_cmd.xs;
                    y_start <= cur_cmd.ys;
                    x_end <= cur_cmd.xe;
                    y_end <= cur_cmd.ye;
                    in_valid <= 1'b1;
                    gap_left = (sender_gaps && $urandom_range(0, 99) < 30) ? gap_length() : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver
    pixel_t want_pix;
    int stall_left = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: pixel (%0d,%0d) transfer with nothing expected",
                             $time, pixel_x, pixel_y);
                    errors++;
                end
                else
                begin
                    want_pix = expected_pixels.pop_front();
                    check_field("pixel_x", 16'(want_pix.x), 16'(pixel_x));
                    check_field("pixel_y", 16'(want_pix.y), 16'(pixel_y));
                    check_field("pixel_alpha", 16'(want_pix.alpha), 16'(pixel_alpha));
                    check_field("visible", 16'(want_pix.vis), 16'(visible));
                    check_field("last", 16'(want_pix.fin), 16'(last));
                    pixels_checked++;
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (receiver_stalls && $urandom_range(0, 99) < 25)
            begin
                stall_left = gap_length() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d pixels outstanding",
                     $time, quiet_cycles, expected_pixels.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_cmd(input logic cmd, input int xs, input int ys, input int xe,
                            input int ye);
        line_cmd_t c;
        begin
            c.command = cmd;
            c.xs = CB'(xs);
            c.ys = CB'(ys);
            c.xe = CB'(xe);
            c.ye = CB'(ye);
            pending_cmds.insert(pending_cmds.size(), c);
        end
    endtask

    task automatic push_advances(input int n);
        for (int k = 0; k < n; k++)
            push_cmd(aalg_pkg::CMD_ADVANCE, $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                     $urandom_range(0, COORD_MAX));
    endtask

    task automatic add_random_line(input int max_len);
        int len;
        int minor;
        int spanx;
        int spany;
        int xa;
        int ya;
        int xb;
        int yb;
        int t;
        int n;
        int style;
        bit steep;
        begin
            len = $urandom_range(0, max_len);
            minor = $urandom_range(0, len);
            steep = $urandom_range(0, 1) && (minor < len);
            spanx = steep ? minor : len;
            spany = steep ? len : minor;
            case ($urandom_range(0, 9))
                0:
                begin
                    xa = 0;
                    ya = 0;
                end
                1:
                begin
                    xa = COORD_MAX - spanx;
                    ya = COORD_MAX - spany;
                end
                default:
                begin
                    xa = $urandom_range(0, COORD_MAX - spanx);
                    ya = $urandom_range(0, COORD_MAX - spany);
                end
            endcase
            xb = xa + spanx;
            yb = ya + spany;
            if ($urandom_range(0, 1))
            begin
                t = ya; ya = yb; yb = t;
            end
            if ($urandom_range(0, 1))
                push_cmd(aalg_pkg::CMD_START, xb, yb, xa, ya);
            else
                push_cmd(aalg_pkg::CMD_START, xa, ya, xb, yb);
            n = (len > 1) ? len - 1 : 0;
            style = $urandom_range(0, 9);
            // abandoned midway by the next start
            if (style == 0 && n > 0)
                n = $urandom_range(0, n - 1);
            push_advances(n);
            items_planned += n + 1;
            // stray advances after the line has ended
            if (style == 1)
                push_advances($urandom_range(1, 2));
        end
    endtask

    task automatic random_phase(input int target, input int max_len);
        int goal;
        int n;
        begin
            goal = items_planned + target;
            while (items_planned < goal)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    n = $urandom_range(0, 3);
                    push_cmd(aalg_pkg::CMD_START, $urandom_range(0, COORD_MAX),
                             $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                             $urandom_range(0, COORD_MAX));
                    push_advances(n);
                    items_planned += n + 1;
                end
                else
                    add_random_line(($urandom_range(0, 5) == 0) ? 20 : max_len);
            end
        end
    endtask

    task automatic wait_idle();
        begin
            while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_alpha(input logic [AB-1:0] value);
        begin
            @(posedge clk);
            cfg_data <= value;
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            alpha_now = value;
            alpha_writes++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // advance with no line, degenerate lines, full-range diagonals
        push_advances(1);
        push_cmd(aalg_pkg::CMD_START, 0, 0, 0, 0);
        push_cmd(aalg_pkg::CMD_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        push_cmd(aalg_pkg::CMD_START, 0, 0, COORD_MAX, COORD_MAX);
        push_advances(2);
        push_cmd(aalg_pkg::CMD_START, COORD_MAX, 0, 0, COORD_MAX);
        push_advances(2);
        push_cmd(aalg_pkg::CMD_START, 0, COORD_MAX, 1, 0);
        push_advances(2);
        push_cmd(aalg_pkg::CMD_START, 5, 5, 6, 5);
        push_cmd(aalg_pkg::CMD_START, 100, 200, 104, 202);
        push_advances(4);
        push_cmd(aalg_pkg::CMD_START, 302, 57, 300, 50);
        push_advances(6);
        wait_idle();

        write_alpha(aalg_pkg::ALPHA_RESET);
        random_phase(20, 8);
        wait_idle();

        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        write_alpha('0);
        random_phase(20, 8);
        wait_idle();

        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        write_alpha(8'd1);
        random_phase(20, 6);
        wait_idle();

        // receiver holds off while the sender keeps offering
        sender_gaps = 1'b0;
        write_alpha(AB'($urandom_range(2, 254)));
        random_phase(25, 8);
        hold_request = 1'b1;
        wait_idle();

        sender_gaps = 1'b1;
        write_alpha(AB'($urandom_range(0, 255)));
        random_phase(20, 12);
        wait_idle();

        $display("summary: %0d commands accepted, %0d pixels checked, %0d alpha writes, %0d holds",
                 cmds_in, pixels_checked, alpha_writes, holds_done);
        $display("summary: %0d steep lines, %0d hidden pixels, %0d pixels clipped at row zero",
                 steep_lines, hidden_pixels, clipped_pixels);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== antialiased_line_generator_core.f =====
sv/aalg_pkg.sv
sv/aalg_divider.sv
sv/antialiased_line_generator_core.sv
bench/testbench.sv
